>>> design/nixf_pkg.sv
`timescale 1ns / 1ps
// Shared constants and helpers for the number to nixie frame converter.
// Used by nixf_cell and number_to_nixie_frame_top; depends on nothing.
package nixf_pkg;

  localparam int NumberW    = 32;
  localparam int FrameW     = 64;
  localparam int GroupW     = 10;
  localparam int DigitW     = 4;
  localparam int DigitCount = 6;

  // Reciprocal of ten scaled by 2^35; exact floor division for 32-bit values.
  localparam logic [NumberW-1:0] RecipTen   = 32'hCCCC_CCCD;
  localparam int                 RecipShift = 35;

  // Bit offset of the group for a digit position, units digit first.
  function automatic int group_offset(input int pos);
    int off;
    case (pos)
      0:       off = 52;
      1:       off = 42;
      2:       off = 32;
      3:       off = 20;
      4:       off = 10;
      default: off = 0;
    endcase
    return off;
  endfunction

endpackage

>>> design/nixf_cell.sv
`timescale 1ns / 1ps
// One pipeline cell: splits the low decimal digit off the running quotient
// and ORs its one-hot group (zero when blanked) into the frame. Depends on nixf_pkg.
module nixf_cell import nixf_pkg::*; #(
  parameter int GroupOffset = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              zeros_on_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [NumberW-1:0] quot_i,
  input  logic [FrameW-1:0]  frame_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [NumberW-1:0] quot_o,
  output logic [FrameW-1:0]  frame_o
);

  logic                   valid_q;
  logic [NumberW-1:0]     quot_d, quot_q;
  logic [FrameW-1:0]      frame_d, frame_q;
  logic [2*NumberW-1:0]   prod;
  logic [DigitW-1:0]      ten_q_low;
  logic [DigitW-1:0]      digit;
  logic [GroupW-1:0]      group;
  logic                   show;

  // The cell empties when its item moves on, so it can take a new one.
  assign ready_o = !valid_q || ready_i;

  assign prod   = {{NumberW{1'b0}}, quot_i} * {{NumberW{1'b0}}, RecipTen};
  assign quot_d = NumberW'(prod[2*NumberW-1:RecipShift]);

  // The remainder is below ten, so only the low four bits of q*10 matter.
  assign ten_q_low = {quot_d[0], 3'b000} + {quot_d[2:0], 1'b0};
  assign digit     = quot_i[DigitW-1:0] - ten_q_low;

  // A position above the top digit has a zero quotient and a zero digit.
  assign show    = (quot_i != '0) || zeros_on_i;
  assign group   = show ? (GroupW'(1) << digit) : '0;
  assign frame_d = frame_i | (FrameW'(group) << GroupOffset);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      quot_q  <= quot_d;
      frame_q <= frame_d;
    end
  end

  assign valid_o = valid_q;
  assign quot_o  = quot_q;
  assign frame_o = frame_q;

endmodule

>>> design/number_to_nixie_frame_top.sv
`timescale 1ns / 1ps
// Top level of the number to nixie frame converter: configuration register
// and a chain of six nixf_cell stages. Depends on nixf_pkg and nixf_cell.
//
// Usage: an input transfer on in_valid_i/in_stall_o carries number_i; the
// matching output transfer on out_valid_o/out_stall_i carries frame_o, the
// 64-bit driver frame with one-hot groups for the low six decimal digits.
// Each of the six cells handles one digit position, units first, and holds
// one register stage. The throughput is one item per cycle while the receiver
// does not stall, since each cell can take a new item as its old one moves on.
// cfg_we_i writes cfg_wdata_i into the leading-zeros setting; 1 shows zeros
// above the top digit, 0 blanks those groups. Write it only while idle.
// Reset empties the chain and sets the leading-zeros setting to 1.
// When the receiver stalls, the last cell holds its frame; earlier cells keep
// moving into empty slots, and in_stall_o rises once the chain is full.
module number_to_nixie_frame_top import nixf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [NumberW-1:0] number_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [FrameW-1:0]  frame_o
);

  logic                zeros_on_q;
  logic                valid_c [DigitCount+1];
  logic                ready_c [DigitCount+1];
  logic [NumberW-1:0]  quot_c  [DigitCount+1];
  logic [FrameW-1:0]   frame_c [DigitCount+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zeros_on_q <= 1'b1;
    end else if (cfg_we_i) begin
      zeros_on_q <= cfg_wdata_i;
    end
  end

  assign valid_c[0] = in_valid_i;
  assign quot_c[0]  = number_i;
  assign frame_c[0] = '0;
  assign in_stall_o = !ready_c[0];

  for (genvar k = 0; k < DigitCount; k++) begin : g_cell
    nixf_cell #(
      .GroupOffset(group_offset(k))
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .zeros_on_i(zeros_on_q),
      .valid_i   (valid_c[k]),
      .ready_o   (ready_c[k]),
      .quot_i    (quot_c[k]),
      .frame_i   (frame_c[k]),
      .valid_o   (valid_c[k+1]),
      .ready_i   (ready_c[k+1]),
      .quot_o    (quot_c[k+1]),
      .frame_o   (frame_c[k+1])
    );
  end

  assign ready_c[DigitCount] = !out_stall_i;
  assign out_valid_o         = valid_c[DigitCount];
  assign frame_o             = frame_c[DigitCount];

  // The quotient leaving the last cell carries digits beyond the sixth.
  logic unused_quot;
  assign unused_quot = ^quot_c[DigitCount];

endmodule
